// ----- sv/stvg_pkg.sv -----
`timescale 1ns / 1ps
package stvg_pkg;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int RAD_W = 16;
	localparam int POS_W = 17;
	localparam int NRM_W = 16;
	localparam int PH_W = 32;
	localparam int DIV_W = 11;
	localparam int ACC_W = 34;
	localparam int TRG_W = 32;
	localparam int CORDIC_STEPS = 18;
	localparam int DIV_STEPS = PH_W;
	localparam int FRONT_DEPTH = DIV_STEPS + CORDIC_STEPS;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 16;
	localparam int SLOT_W = 3;
	localparam int MAX_DIVISIONS_DEF = 256;
	localparam int POS_FRAC_BITS_DEF = 12;
	localparam int NORM_ONE = 16384;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd2;

	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd4096;
	localparam logic [CNT_W-1:0] SECTORS_RST = 9'd36;
	localparam logic [CNT_W-1:0] STACKS_RST = 9'd18;

	localparam logic [ACC_W-1:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [PH_W-1:0] HALF_TURN = 32'h8000_0000;

	// vertex slots: upper triangle A,B,C then lower triangle C,B,D
	localparam logic [SLOT_W-1:0] SLOT_UP_A = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_UP_B = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_UP_C = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_LO_C = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_LO_B = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_LO_D = 3'd5;

	typedef struct packed {
		logic signed [TRG_W-1:0] co;
		logic signed [TRG_W-1:0] si;
	} trig_t;

	typedef struct packed {
		logic busy;
		logic free;
	} seq_stat_t;

	function automatic logic [PH_W-1:0] atan_turn(input int k);
		logic [PH_W-1:0] r;
		case (k)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [63:0] round_shr(input logic signed [63:0] v, input int k);
		logic signed [63:0] b;
		b = 64'sd1 <<< (k - 1);
		return (v + b) >>> k;
	endfunction

	function automatic logic signed [63:0] sat(input logic signed [63:0] v,
			input logic signed [63:0] lim);
		logic signed [63:0] r;
		r = v;
		if (v > lim) r = lim;
		if (v < -lim) r = -lim;
		return r;
	endfunction
endpackage

// ----- sv/stvg_if.sv -----
`timescale 1ns / 1ps
interface stvg_in_if;
	logic valid;
	logic ready;
	logic [stvg_pkg::IDX_W-1:0] stack_index;
	logic [stvg_pkg::IDX_W-1:0] sector_index;
	modport source(output valid, output stack_index, output sector_index, input ready);
	modport sink(input valid, input stack_index, input sector_index, output ready);
endinterface

interface stvg_out_if;
	logic valid;
	logic ready;
	logic signed [stvg_pkg::POS_W-1:0] pos_x;
	logic signed [stvg_pkg::POS_W-1:0] pos_y;
	logic signed [stvg_pkg::POS_W-1:0] pos_z;
	logic signed [stvg_pkg::NRM_W-1:0] norm_x;
	logic signed [stvg_pkg::NRM_W-1:0] norm_y;
	logic signed [stvg_pkg::NRM_W-1:0] norm_z;
	logic last;
	modport source(output valid, output pos_x, output pos_y, output pos_z, output norm_x,
		output norm_y, output norm_z, output last, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, input norm_x,
		input norm_y, input norm_z, input last, output ready);
endinterface

// ----- sv/stvg_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage
module stvg_div (
	input  logic clk,
	input  logic en,
	input  logic [stvg_pkg::DIV_W-1:0] rem_in,
	input  logic [stvg_pkg::PH_W-1:0] num_in,
	input  logic [stvg_pkg::DIV_W-1:0] dvsr,
	output logic [stvg_pkg::PH_W-1:0] quo
);
	import stvg_pkg::*;

	logic [DIV_W-1:0] rem_s [DIV_STEPS];
	logic [PH_W-1:0] nq_s [DIV_STEPS];

	for (genvar s = 0; s < DIV_STEPS; s++) begin : g_st
		logic [DIV_W-1:0] r_prev;
		logic [PH_W-1:0] n_prev;
		logic [DIV_W:0] t;
		logic ge;
		if (s == 0) begin : g_first
			assign r_prev = rem_in;
			assign n_prev = num_in;
		end else begin : g_next
			assign r_prev = rem_s[s-1];
			assign n_prev = nq_s[s-1];
		end
		assign t = {r_prev, n_prev[PH_W-1]};
		assign ge = t >= {1'b0, dvsr};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s] <= ge ? DIV_W'(t - {1'b0, dvsr}) : t[DIV_W-1:0];
				nq_s[s] <= {n_prev[PH_W-2:0], ge};
			end
		end
	end

	assign quo = nq_s[DIV_STEPS-1];
endmodule

// ----- sv/stvg_cordic.sv -----
`timescale 1ns / 1ps
module stvg_cordic (
	input  logic clk,
	input  logic en,
	input  logic [stvg_pkg::PH_W-1:0] phase,
	output stvg_pkg::trig_t res
);
	import stvg_pkg::*;

	logic signed [ACC_W-1:0] x_s [CORDIC_STEPS];
	logic signed [ACC_W-1:0] y_s [CORDIC_STEPS];
	logic signed [ACC_W-1:0] z_s [CORDIC_STEPS];
	logic flip_s [CORDIC_STEPS];

	logic fold;
	logic [PH_W-1:0] a;
	logic signed [ACC_W-1:0] x_fin, y_fin;

	// fold into the half turn around zero, negate at the end
	assign fold = (phase[PH_W-1:PH_W-2] == 2'b01) || (phase[PH_W-1:PH_W-2] == 2'b10);
	assign a = fold ? (phase ^ HALF_TURN) : phase;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_st
		logic signed [ACC_W-1:0] xp, yp, zp, xs, ys, at;
		logic fp;
		if (k == 0) begin : g_first
			assign xp = CORDIC_GAIN;
			assign yp = '0;
			assign zp = ACC_W'($signed(a));
			assign fp = fold;
		end else begin : g_next
			assign xp = x_s[k-1];
			assign yp = y_s[k-1];
			assign zp = z_s[k-1];
			assign fp = flip_s[k-1];
		end
		assign xs = xp >>> k;
		assign ys = yp >>> k;
		assign at = $signed(ACC_W'(atan_turn(k)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[ACC_W-1]) begin
					x_s[k] <= xp - ys;
					y_s[k] <= yp + xs;
					z_s[k] <= zp - at;
				end else begin
					x_s[k] <= xp + ys;
					y_s[k] <= yp - xs;
					z_s[k] <= zp + at;
				end
				flip_s[k] <= fp;
			end
		end
	end

	assign x_fin = flip_s[CORDIC_STEPS-1] ? -x_s[CORDIC_STEPS-1] : x_s[CORDIC_STEPS-1];
	assign y_fin = flip_s[CORDIC_STEPS-1] ? -y_s[CORDIC_STEPS-1] : y_s[CORDIC_STEPS-1];
	assign res.co = x_fin[TRG_W-1:0];
	assign res.si = y_fin[TRG_W-1:0];
endmodule

// ----- sv/stvg_emit.sv -----
`timescale 1ns / 1ps
module stvg_emit #(
	parameter int POS_FRAC_BITS = stvg_pkg::POS_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  stvg_pkg::trig_t st0,
	input  stvg_pkg::trig_t st1,
	input  stvg_pkg::trig_t se0,
	input  stvg_pkg::trig_t se1,
	input  logic upper,
	input  logic lower,
	input  logic [stvg_pkg::RAD_W-1:0] radius,
	output stvg_pkg::seq_stat_t stat,
	stvg_out_if.source vtx_out
);
	import stvg_pkg::*;

	localparam logic signed [63:0] PMAX = (64'sd1 <<< (POS_FRAC_BITS + 4)) - 64'sd1;
	localparam logic signed [63:0] NMAX = 64'(NORM_ONE);

	trig_t st0_q, st1_q, se0_q, se1_q;
	logic lower_q, seq_v_q;
	logic [SLOT_W-1:0] cnt_q;
	logic ev, is_end, free, issue;
	trig_t row, col;

	logic v_s1, last_s1;
	logic signed [63:0] px_s1, py_s1;
	logic signed [TRG_W-1:0] sz_s1;

	logic v_s2, last_s2;
	logic signed [63:0] rx_s2, ry_s2, rz_s2;
	logic signed [NRM_W-1:0] nx_s2, ny_s2, nz_s2;

	logic signed [63:0] pxr, pyr;

	assign ev = !vtx_out.valid || vtx_out.ready;
	assign is_end = cnt_q == (lower_q ? SLOT_LO_D : SLOT_UP_C);
	assign free = !seq_v_q || (ev && is_end);
	assign issue = seq_v_q && ev;
	assign stat.busy = seq_v_q;
	assign stat.free = free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q <= 1'b0;
			cnt_q <= SLOT_UP_A;
		end else if (free) begin
			seq_v_q <= in_valid;
			cnt_q <= upper ? SLOT_UP_A : SLOT_LO_C;
		end else if (issue) begin
			cnt_q <= cnt_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (free && in_valid) begin
			st0_q <= st0;
			st1_q <= st1;
			se0_q <= se0;
			se1_q <= se1;
			lower_q <= lower;
		end
	end

	always_comb begin
		case (cnt_q) inside
			SLOT_UP_B, SLOT_LO_B, SLOT_LO_D: row = st1_q;
			default: row = st0_q;
		endcase
		case (cnt_q) inside
			SLOT_UP_C, SLOT_LO_C, SLOT_LO_D: col = se1_q;
			default: col = se0_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vtx_out.valid <= 1'b0;
		end else if (ev) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			vtx_out.valid <= v_s2;
		end
	end

	assign pxr = round_shr(px_s1, 30);
	assign pyr = round_shr(py_s1, 30);

	always_ff @(posedge clk) begin
		if (ev) begin
			px_s1 <= row.co * col.co;
			py_s1 <= row.co * col.si;
			sz_s1 <= row.si;
			last_s1 <= is_end;

			rx_s2 <= $signed({1'b0, radius}) * $signed(pxr[ACC_W-1:0]);
			ry_s2 <= $signed({1'b0, radius}) * $signed(pyr[ACC_W-1:0]);
			rz_s2 <= $signed({1'b0, radius}) * sz_s1;
			nx_s2 <= NRM_W'(sat(round_shr(pxr, 16), NMAX));
			ny_s2 <= NRM_W'(sat(round_shr(pyr, 16), NMAX));
			nz_s2 <= NRM_W'(sat(round_shr(64'(sz_s1), 16), NMAX));
			last_s2 <= last_s1;

			vtx_out.pos_x <= POS_W'(sat(round_shr(rx_s2, 30), PMAX));
			vtx_out.pos_y <= POS_W'(sat(round_shr(ry_s2, 30), PMAX));
			vtx_out.pos_z <= POS_W'(sat(round_shr(rz_s2, 30), PMAX));
			vtx_out.norm_x <= nx_s2;
			vtx_out.norm_y <= ny_s2;
			vtx_out.norm_z <= nz_s2;
			vtx_out.last <= last_s2;
		end
	end
endmodule

// ----- sv/sphere_triangle_vertex_generator.sv -----
`timescale 1ns / 1ps
// Emits the triangle vertices (position Q4.12, normal Q1.14) of one cell of a
// latitude-longitude sphere. A cell enters a 50-stage front end (four 32-stage
// bit-per-stage dividers for the grid angles, then four 18-stage CORDICs) and a
// new cell can enter every cycle while the front end is not stalled; the vertex
// sequencer then sends one vertex per cycle while the output is ready, six per
// cell, or three on the first and last stack. Cells outside the configured counts
// are taken and dropped. Write the registers only while no cell is in flight.
module sphere_triangle_vertex_generator #(
	parameter int MAX_DIVISIONS = stvg_pkg::MAX_DIVISIONS_DEF,
	parameter int POS_FRAC_BITS = stvg_pkg::POS_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [stvg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [stvg_pkg::CFG_W-1:0] cfg_data,
	stvg_in_if.sink cell_in,
	stvg_out_if.source vtx_out
);
	import stvg_pkg::*;

	localparam logic [DIV_W-1:0] MAXC = DIV_W'(MAX_DIVISIONS);

	logic [RAD_W-1:0] radius_q;
	logic [CNT_W-1:0] sectors_q, stacks_q;
	logic [DIV_W-1:0] n_cnt, s_cnt, s_dbl;
	logic [DIV_W-1:0] i0, i1, j0, j1, j1r;
	logic in_rng, front_en, v_end;
	logic [PH_W-1:0] q_st0, q_st1, q_se0, q_se1;
	logic [PH_W-1:0] stack_low, sector_low;
	trig_t t_st0, t_st1, t_se0, t_se1;
	seq_stat_t stat;

	logic v_sn [FRONT_DEPTH];
	logic up_sn [FRONT_DEPTH];
	logic lo_sn [FRONT_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			sectors_q <= SECTORS_RST;
			stacks_q <= STACKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				REG_SECTORS: sectors_q <= cfg_data[CNT_W-1:0];
				REG_STACKS: stacks_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		s_cnt = DIV_W'(stacks_q);
		if (s_cnt < DIV_W'(2)) s_cnt = DIV_W'(2);
		if (s_cnt > MAXC) s_cnt = MAXC;
		n_cnt = DIV_W'(sectors_q);
		if (n_cnt < DIV_W'(3)) n_cnt = DIV_W'(3);
		if (n_cnt > MAXC) n_cnt = MAXC;
	end

	assign s_dbl = s_cnt << 1;
	assign i0 = DIV_W'(cell_in.stack_index);
	assign i1 = i0 + DIV_W'(1);
	assign j0 = DIV_W'(cell_in.sector_index);
	assign j1 = j0 + DIV_W'(1);
	assign j1r = (j1 == n_cnt) ? '0 : j1;
	assign stack_low = PH_W'({s_cnt[DIV_W-1:1], 1'b0});
	assign sector_low = PH_W'(n_cnt[DIV_W-1:1]);
	assign in_rng = (i0 < s_cnt) && (j0 < n_cnt);

	assign v_end = v_sn[FRONT_DEPTH-1];
	assign front_en = !v_end || stat.free;
	assign cell_in.ready = front_en;

	for (genvar s = 0; s < FRONT_DEPTH; s++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[s] <= 1'b0;
			end else if (front_en) begin
				v_sn[s] <= (s == 0) ? (cell_in.valid && in_rng) : v_sn[(s == 0) ? 0 : s-1];
			end
		end
		always_ff @(posedge clk) begin
			if (front_en) begin
				up_sn[s] <= (s == 0) ? (i0 != '0) : up_sn[(s == 0) ? 0 : s-1];
				lo_sn[s] <= (s == 0) ? (i0 != s_cnt - DIV_W'(1)) : lo_sn[(s == 0) ? 0 : s-1];
			end
		end
	end

	stvg_div u_div_st0 (.clk, .en(front_en), .rem_in(i0), .num_in(stack_low),
		.dvsr(s_dbl), .quo(q_st0));
	stvg_div u_div_st1 (.clk, .en(front_en), .rem_in(i1), .num_in(stack_low),
		.dvsr(s_dbl), .quo(q_st1));
	stvg_div u_div_se0 (.clk, .en(front_en), .rem_in(j0), .num_in(sector_low),
		.dvsr(n_cnt), .quo(q_se0));
	stvg_div u_div_se1 (.clk, .en(front_en), .rem_in(j1r), .num_in(sector_low),
		.dvsr(n_cnt), .quo(q_se1));

	stvg_cordic u_cor_st0 (.clk, .en(front_en), .phase(QUARTER_TURN - q_st0), .res(t_st0));
	stvg_cordic u_cor_st1 (.clk, .en(front_en), .phase(QUARTER_TURN - q_st1), .res(t_st1));
	stvg_cordic u_cor_se0 (.clk, .en(front_en), .phase(q_se0), .res(t_se0));
	stvg_cordic u_cor_se1 (.clk, .en(front_en), .phase(q_se1), .res(t_se1));

	stvg_emit #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_emit (
		.clk,
		.arst_n,
		.in_valid(v_end),
		.st0(t_st0),
		.st1(t_st1),
		.se0(t_se0),
		.se1(t_se1),
		.upper(up_sn[FRONT_DEPTH-1]),
		.lower(lo_sn[FRONT_DEPTH-1]),
		.radius(radius_q),
		.stat,
		.vtx_out
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!front_en |-> (v_end && stat.busy))
		else $error("front end stalled without a waiting cell");

	a_idle_seq_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy |-> front_en)
		else $error("idle sequencer blocked the front end");
endmodule

// ----- verif/sphere_triangle_vertex_generator_tb.sv -----
`timescale 1ns / 1ps
module sphere_triangle_vertex_generator_tb;
	import stvg_pkg::*;

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} cell_t;

	typedef struct {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic last;
	} vertex_t;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	stvg_in_if cell_in();
	stvg_out_if vtx_out();

	sphere_triangle_vertex_generator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cell_in(cell_in.sink),
		.vtx_out(vtx_out.source)
	);

	always #5 clk = ~clk;

	cell_t cell_q[$];
	vertex_t vertex_q[$];
	logic [RAD_W-1:0] radius_r = RADIUS_RST;
	logic [CNT_W-1:0] sectors_r = SECTORS_RST;
	logic [CNT_W-1:0] stacks_r = STACKS_RST;
	int errors = 0;
	int cells_sent = 0;
	int words_seen = 0;
	logic quiet = 1'b0;
	logic long_hold_go = 1'b0;

	function automatic void cordic(input logic [31:0] ph, output longint co, output longint si);
		longint x, y, z, xs, ys;
		logic flip;
		x = longint'(CORDIC_GAIN);
		y = 0;
		flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
		if (flip) ph = ph - HALF_TURN;
		z = longint'($signed(ph));
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'(atan_turn(k));
			end else begin
				x = x + ys; y = y - xs; z = z + longint'(atan_turn(k));
			end
		end
		co = flip ? -x : x;
		si = flip ? -y : y;
	endfunction

	function automatic longint rnd(input longint v, input int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic void push_vertex(input longint cst, input longint sst, input longint cse,
			input longint sse, input logic lst);
		vertex_t v;
		longint pmax, px, py, rad;
		pmax = (longint'(1) <<< (POS_FRAC_BITS_DEF + 4)) - 1;
		rad = longint'(radius_r);
		px = rnd(cst * cse, 30);
		py = rnd(cst * sse, 30);
		v.px = POS_W'(clip(rnd(rad * px, 30), pmax));
		v.py = POS_W'(clip(rnd(rad * py, 30), pmax));
		v.pz = POS_W'(clip(rnd(rad * sst, 30), pmax));
		v.nx = NRM_W'(clip(rnd(px, 16), NORM_ONE));
		v.ny = NRM_W'(clip(rnd(py, 16), NORM_ONE));
		v.nz = NRM_W'(clip(rnd(sst, 16), NORM_ONE));
		v.last = lst;
		vertex_q = {vertex_q, v};
	endfunction

	function automatic void predict_cell(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		logic [63:0] s, n, i, j;
		logic [31:0] st0, st1, se0, se1;
		longint c0, s0, c1, s1, ca, sa, cb, sb;
		logic up, lo;
		s = stacks_r < 2 ? 2 : (stacks_r > MAX_DIVISIONS_DEF ? MAX_DIVISIONS_DEF : stacks_r);
		n = sectors_r < 3 ? 3 : (sectors_r > MAX_DIVISIONS_DEF ? MAX_DIVISIONS_DEF : sectors_r);
		i = row;
		j = col;
		if (i >= s || j >= n) return;
		st0 = QUARTER_TURN - 32'(((i << 31) + s / 2) / s);
		st1 = QUARTER_TURN - 32'((((i + 1) << 31) + s / 2) / s);
		se0 = 32'(((j << 32) + n / 2) / n);
		se1 = 32'((((j + 1) << 32) + n / 2) / n);
		cordic(st0, c0, s0);
		cordic(st1, c1, s1);
		cordic(se0, ca, sa);
		cordic(se1, cb, sb);
		up = (i != 0);
		lo = (i != s - 1);
		if (up) begin
			push_vertex(c0, s0, ca, sa, 1'b0);
			push_vertex(c1, s1, ca, sa, 1'b0);
			push_vertex(c0, s0, cb, sb, !lo);
		end
		if (lo) begin
			push_vertex(c0, s0, cb, sb, 1'b0);
			push_vertex(c1, s1, ca, sa, 1'b0);
			push_vertex(c1, s1, cb, sb, 1'b1);
		end
	endfunction

	// driver
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_in.valid <= 1'b0;
			cell_in.stack_index <= '0;
			cell_in.sector_index <= '0;
			gap_left <= 0;
		end else begin
			if (cell_in.valid && cell_in.ready) begin
				predict_cell(cell_in.stack_index, cell_in.sector_index);
				cells_sent <= cells_sent + 1;
			end
			if (!cell_in.valid || cell_in.ready) begin
				if (gap_left > 0) begin
					cell_in.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cell_q.size() > 0) begin
					cell_t c;
					c = cell_q.pop_front();
					cell_in.stack_index <= c.row;
					cell_in.sector_index <= c.col;
					cell_in.valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 16);
				end else begin
					cell_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_out.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (vtx_out.valid && vtx_out.ready) begin
				words_seen <= words_seen + 1;
				if (vertex_q.size() == 0) begin
					$error("unexpected vertex word");
					errors <= errors + 1;
				end else begin
					vertex_t e;
					int bad;
					e = vertex_q.pop_front();
					bad = 0;
					if (vtx_out.pos_x !== e.px) begin
						$error("pos_x exp %0d got %0d", e.px, vtx_out.pos_x); bad++;
					end
					if (vtx_out.pos_y !== e.py) begin
						$error("pos_y exp %0d got %0d", e.py, vtx_out.pos_y); bad++;
					end
					if (vtx_out.pos_z !== e.pz) begin
						$error("pos_z exp %0d got %0d", e.pz, vtx_out.pos_z); bad++;
					end
					if (vtx_out.norm_x !== e.nx) begin
						$error("norm_x exp %0d got %0d", e.nx, vtx_out.norm_x); bad++;
					end
					if (vtx_out.norm_y !== e.ny) begin
						$error("norm_y exp %0d got %0d", e.ny, vtx_out.norm_y); bad++;
					end
					if (vtx_out.norm_z !== e.nz) begin
						$error("norm_z exp %0d got %0d", e.nz, vtx_out.norm_z); bad++;
					end
					if (vtx_out.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, vtx_out.last); bad++;
					end
					errors <= errors + bad;
				end
			end
			if (long_hold_go && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				vtx_out.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				vtx_out.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				vtx_out.ready <= 1'b0;
			end else begin
				vtx_out.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 16);
			end
		end
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((cell_in.valid && cell_in.ready) || (vtx_out.valid && vtx_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RADIUS: radius_r = data;
			REG_SECTORS: sectors_r = data[CNT_W-1:0];
			REG_STACKS: stacks_r = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic setup(input int rad, input int sec, input int stk);
		write_reg(REG_RADIUS, CFG_W'(rad));
		write_reg(REG_SECTORS, CFG_W'(sec));
		write_reg(REG_STACKS, CFG_W'(stk));
	endtask

	task automatic add_cell(input int r, input int c);
		cell_t x;
		x.row = IDX_W'(r);
		x.col = IDX_W'(c);
		cell_q = {cell_q, x};
	endtask

	// checked twice so a word just taken from the queue is seen on the port
	task automatic wait_idle();
		repeat (2) begin
			while (cell_q.size() > 0 || cell_in.valid || vertex_q.size() > 0) @(posedge clk);
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_cells(input int count);
		int s, n;
		s = stacks_r < 2 ? 2 : (stacks_r > 256 ? 256 : stacks_r);
		n = sectors_r < 3 ? 3 : (sectors_r > 256 ? 256 : sectors_r);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 6) == 0)
				add_cell($urandom_range(0, 255), $urandom_range(0, 255));
			else
				add_cell($urandom_range(0, s - 1), $urandom_range(0, n - 1));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: poles, seam, out of range
		add_cell(0, 0); add_cell(17, 0); add_cell(17, 35); add_cell(1, 5);
		add_cell(18, 0); add_cell(0, 36); add_cell(255, 255); add_cell(5, 35);
		wait_idle();

		// max radius saturates, minimum counts, bad index ignored
		setup(65535, 3, 2);
		write_reg(REG_UNUSED, 16'hFFFF);
		add_cell(0, 0); add_cell(1, 2); add_cell(0, 2); add_cell(2, 0); add_cell(1, 3);
		wait_idle();

		// zero radius, max counts
		setup(0, 256, 256);
		add_cell(0, 0); add_cell(255, 255); add_cell(128, 64); add_cell(1, 170);
		wait_idle();

		// counts clamped from both sides
		setup(1, 0, 511);
		add_cell(0, 2); add_cell(255, 1); add_cell(100, 3); add_cell(7, 0);
		wait_idle();

		// random with a long output hold-off to back up the pipe
		setup($urandom_range(1, 65535), $urandom_range(3, 256), $urandom_range(2, 256));
		random_cells(40);
		@(posedge clk);
		long_hold_go <= 1'b1;
		wait_idle();

		setup($urandom_range(0, 65535), $urandom_range(3, 64), $urandom_range(2, 32));
		random_cells(35);
		wait_idle();

		// no idling in the last stretch
		quiet = 1'b1;
		setup($urandom_range(0, 65535), $urandom_range(0, 511), $urandom_range(0, 511));
		random_cells(35);
		wait_idle();

		$display("Sent %0d cells over 7 register settings, checked %0d vertex words.",
			cells_sent, words_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
